@@ hdl/deq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, codes and default sizes for the double-ended queue unit.
// ----------------------------------------------------------------------------
package deq_pkg;

  // default sizes
  localparam int DEQ_DEPTH      = 16;
  localparam int DEQ_DATA_WIDTH = 32;

  // field widths of the action and status codes
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;

  // requested action of one input beat
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_BACK  = 3'd5
  } action_t;

  // status code of one result beat
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

@@ hdl/double_ended_queue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue kept in a ring buffer held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel takes one action per beat: push front, push back, pop
//   front, pop back, peek front or peek back, with in_data_in as the word to
//   store for pushes. Every input beat yields exactly one out_ beat carrying
//   the word read (zero for pushes, errors and unknown codes), a status code
//   (ok, empty, full), the empty flag and the entry count after the action.
//   The result sits in the output register the cycle after the input beat
//   is taken, while the RAM read data arrives with it. Throughput is one
//   action per cycle while the receiver takes each beat; pointers and
//   count live in flops and update at the accept edge, and a write done at
//   one edge is visible to a read issued at the next, so back-to-back
//   actions need no interlock. When the receiver stalls, the output
//   register holds its beat and in_ready drops until the beat is taken.
//   Reset empties the queue (pointers and count cleared); RAM contents are
//   not cleared, since only held entries are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
  parameter int DEPTH      = deq_pkg::DEQ_DEPTH,
  parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [deq_pkg::ACTION_W-1:0] in_action,
  input  logic [DATA_WIDTH-1:0]        in_data_in,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [DATA_WIDTH-1:0]        out_data_out,
  output logic [deq_pkg::STATUS_W-1:0] out_status,
  output logic                         out_is_empty,
  output logic [$clog2(DEPTH+1)-1:0]   out_entry_count
);
  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  // ring storage
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  // queue pointers and fill level
  logic [AW-1:0] front_r, front_nxt;
  logic [AW-1:0] back_r, back_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // output register
  logic          out_valid_r;
  logic          out_rd_r, out_rd_nxt;
  status_t       out_status_r, out_status_nxt;
  logic [CW-1:0] out_count_r;

  // ram access for the current beat
  logic          accept;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;

  // neighbor slots with wrap in either direction
  logic [AW-1:0] front_prev, front_next, back_prev, back_next;
  logic          is_full, is_empty;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign front_prev = (front_r == '0) ? LAST_SLOT : front_r - AW'(1);
  assign front_next = (front_r == LAST_SLOT) ? '0 : front_r + AW'(1);
  assign back_prev  = (back_r == '0) ? LAST_SLOT : back_r - AW'(1);
  assign back_next  = (back_r == LAST_SLOT) ? '0 : back_r + AW'(1);
  assign is_full    = (count_r == FULL_CNT);
  assign is_empty   = (count_r == '0);

  // action decode
  always_comb begin
    front_nxt      = front_r;
    back_nxt       = back_r;
    count_nxt      = count_r;
    wr_en          = 1'b0;
    wr_addr        = front_prev;
    rd_en          = 1'b0;
    rd_addr        = front_r;
    out_rd_nxt     = 1'b0;
    out_status_nxt = ST_OK;
    unique case (action_t'(in_action))
      ACT_PUSH_FRONT: begin
        if (is_full) begin
          out_status_nxt = ST_FULL;
        end else begin
          wr_en     = accept;
          wr_addr   = front_prev;
          front_nxt = front_prev;
          count_nxt = count_r + CW'(1);
        end
      end
      ACT_PUSH_BACK: begin
        if (is_full) begin
          out_status_nxt = ST_FULL;
        end else begin
          wr_en     = accept;
          wr_addr   = back_r;
          back_nxt  = back_next;
          count_nxt = count_r + CW'(1);
        end
      end
      ACT_POP_FRONT, ACT_PEEK_FRONT: begin
        if (is_empty) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          rd_en      = accept;
          rd_addr    = front_r;
          out_rd_nxt = 1'b1;
          if (action_t'(in_action) == ACT_POP_FRONT) begin
            front_nxt = front_next;
            count_nxt = count_r - CW'(1);
          end
        end
      end
      ACT_POP_BACK, ACT_PEEK_BACK: begin
        if (is_empty) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          rd_en      = accept;
          rd_addr    = back_prev;
          out_rd_nxt = 1'b1;
          if (action_t'(in_action) == ACT_POP_BACK) begin
            back_nxt  = back_prev;
            count_nxt = count_r - CW'(1);
          end
        end
      end
      default: begin
        // unknown codes leave the queue as it is
      end
    endcase
  end

  // ram write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data_in;
    end
  end

  // ram read port, registered data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // pointers, count and output control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      back_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        front_r     <= front_nxt;
        back_r      <= back_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload of the beat just taken
  always_ff @(posedge clk) begin
    if (accept) begin
      out_rd_r     <= out_rd_nxt;
      out_status_r <= out_status_nxt;
      out_count_r  <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_out    = out_rd_r ? rd_data_r : '0;
  assign out_status      = out_status_r;
  assign out_is_empty    = (out_count_r == '0);
  assign out_entry_count = out_count_r;

endmodule
